[src/psd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants for the program stream directory parser.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int unsigned MaxUnits  = 64;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);
  localparam int unsigned BufDepth  = 18;
  localparam int unsigned BufIdxW   = $clog2(BufDepth);

  localparam logic [7:0]  StreamIdExt = 8'hFD;
  localparam logic [7:0]  StartLast   = 8'hFF;
  localparam logic [7:0]  StartThird  = 8'h01;
  localparam logic [7:0]  StartZero   = 8'h00;
  localparam logic [15:0] MinLen      = 16'd14;
  localparam logic [16:0] HdrOverhead = 17'd6;

  // byte positions inside the packet
  localparam logic [16:0] PosStart3   = 17'd2;
  localparam logic [16:0] PosStart4   = 17'd3;
  localparam logic [16:0] PosLenHi    = 17'd4;
  localparam logic [16:0] PosLenLo    = 17'd5;
  localparam logic [16:0] PosCountHi  = 17'd6;
  localparam logic [16:0] PosCountLo  = 17'd7;
  localparam logic [16:0] PosHdrLast  = 17'd19;
  localparam logic [16:0] PosUnit0    = 17'd20;

  localparam logic [BufIdxW-1:0] UnitLastIdx = BufIdxW'(BufDepth - 1);

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_UNIT   = 2'd1,
    KIND_BAD    = 2'd2,
    KIND_TRUNC  = 2'd3
  } psd_kind_e;

  typedef enum logic {
    PH_IDLE   = 1'b0,
    PH_ACTIVE = 1'b1
  } psd_phase_e;

  // one queued operation for the back end
  typedef struct packed {
    logic [7:0]         data;
    logic [BufIdxW-1:0] widx;
    logic               we;
    logic               emit;
    psd_kind_e          kind;
  } psd_op_t;

  typedef struct packed {
    psd_kind_e    kind;
    logic [14:0]  unit_count;
    logic [44:0]  prev_dir_offset;
    logic [44:0]  next_dir_offset;
    logic [7:0]   stream_id;
    logic [44:0]  header_position;
    logic [15:0]  ref_offset;
    logic [32:0]  pts;
    logic [22:0]  read_size;
    logic         intra_coded;
    logic [1:0]   coding_params;
    logic [6:0]   stream_id_ext;
  } psd_rec_t;

endpackage

[src/program_stream_directory_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// program_stream_directory_parser_top
// Parses directory packet bytes into header, access-unit and error records.
//
//   channel   handshake               payload
//   input     in_valid_i/in_ready_o   data_byte_i, first_byte_i, last_byte_i
//   output    out_valid_o/out_ready_i record_kind_o .. stream_id_ext_o
//
// one byte accepted per cycle while in_ready_o is high; a record-emitting byte goes
// to a queue entry, then from the queue head to the back end output register and out_valid_o.
// reset clears the parse state, the operation queue and the output valid.
// a stalled output holds the back end at the next record-emitting op; the
// 4-entry queue behind it fills and in_ready_o drops until the record is taken.
// ----------------------------------------------------------------------------
module program_stream_directory_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  record_kind_o,
  output logic [14:0] unit_count_o,
  output logic [44:0] prev_dir_offset_o,
  output logic [44:0] next_dir_offset_o,
  output logic [7:0]  stream_id_o,
  output logic [44:0] header_position_o,
  output logic [15:0] ref_offset_o,
  output logic [32:0] pts_o,
  output logic [22:0] read_size_o,
  output logic        intra_coded_o,
  output logic [1:0]  coding_params_o,
  output logic [6:0]  stream_id_ext_o
);
  import psd_pkg::*;

  logic     push, q_full, head_valid, pop;
  psd_op_t  op, head;
  psd_rec_t rec;

  psd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .full_i       (q_full),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .push_o       (push),
    .op_o         (op)
  );

  psd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid),
    .full_o  (q_full)
  );

  psd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .rec_o        (rec)
  );

  assign in_ready_o        = !q_full;
  assign record_kind_o     = rec.kind;
  assign unit_count_o      = rec.unit_count;
  assign prev_dir_offset_o = rec.prev_dir_offset;
  assign next_dir_offset_o = rec.next_dir_offset;
  assign stream_id_o       = rec.stream_id;
  assign header_position_o = rec.header_position;
  assign ref_offset_o      = rec.ref_offset;
  assign pts_o             = rec.pts;
  assign read_size_o       = rec.read_size;
  assign intra_coded_o     = rec.intra_coded;
  assign coding_params_o   = rec.coding_params;
  assign stream_id_ext_o   = rec.stream_id_ext;

endmodule

[src/psd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_front
// Byte classifier: tracks packet position, checks start code and length,
// and issues buffer-write and record-emit operations to the queue.
// ----------------------------------------------------------------------------
module psd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              full_i,
  input  logic [7:0]        data_byte_i,
  input  logic              first_byte_i,
  input  logic              last_byte_i,
  output logic              push_o,
  output psd_pkg::psd_op_t  op_o
);
  import psd_pkg::*;

  psd_phase_e         phase_q, phase_d;
  logic [16:0]        pos_q, pos_d;
  logic [15:0]        len_q, len_d;
  logic [14:0]        ann_q, ann_d;
  logic [14:0]        done_q, done_d;
  logic [BufIdxW-1:0] widx_q, widx_d;

  logic        go, active;
  logic [16:0] p, p1, pkt_end;
  logic [15:0] len_cur;
  logic [7:0]  want;
  logic [14:0] limit;
  logic        at_end, bad, trunc, hdr, unit, store;

  assign active  = first_byte_i || (phase_q == PH_ACTIVE);
  assign go      = in_valid_i && !full_i && active;
  assign p       = first_byte_i ? 17'd0 : pos_q;
  assign p1      = p + 17'd1;
  assign len_cur = (p == PosLenLo) ? {len_q[15:8], data_byte_i} : len_q;
  assign pkt_end = {1'b0, len_cur} + HdrOverhead;
  assign at_end  = (p >= PosLenLo) && (p1 >= pkt_end);
  assign limit   = (ann_q < 15'(MaxUnits)) ? ann_q : 15'(MaxUnits);

  always_comb begin
    if (p == PosStart4) begin
      want = StartLast;
    end else if (p == PosStart3) begin
      want = StartThird;
    end else begin
      want = StartZero;
    end
  end

  assign bad   = ((p < PosLenHi) && (data_byte_i != want)) ||
                 ((p == PosLenLo) && (len_cur < MinLen));
  assign trunc = !bad && last_byte_i && !at_end;
  assign hdr   = !bad && !trunc && (p == PosHdrLast);
  assign unit  = !bad && !trunc && (p >= PosUnit0) && (widx_q == UnitLastIdx) &&
                 (done_q < limit);
  assign store = p >= PosCountHi;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (go) begin
      if (bad || trunc || at_end) begin
        phase_d = PH_IDLE;
      end else begin
        phase_d = PH_ACTIVE;
      end
    end
  end

  // counters and queue operation
  always_comb begin
    pos_d  = pos_q;
    len_d  = len_q;
    ann_d  = ann_q;
    done_d = done_q;
    widx_d = widx_q;
    if (go) begin
      pos_d = p1;
      if (p == PosLenHi) begin
        len_d = {data_byte_i, 8'h00};
      end
      if (p == PosLenLo) begin
        len_d = len_cur;
      end
      if (p == PosCountHi) begin
        ann_d[14:7] = data_byte_i;
      end
      if (p == PosCountLo) begin
        ann_d[6:0] = data_byte_i[7:1];
      end
      if (hdr) begin
        done_d = '0;
      end else if (unit) begin
        done_d = done_q + 15'd1;
      end
      if ((p <= PosLenLo) || (p == PosHdrLast) || (widx_q == UnitLastIdx)) begin
        widx_d = '0;
      end else begin
        widx_d = widx_q + BufIdxW'(1);
      end
    end

    push_o    = go && (store || bad || trunc || hdr || unit);
    op_o.data = data_byte_i;
    op_o.widx = widx_q;
    op_o.we   = store && !bad;
    op_o.emit = bad || trunc || hdr || unit;
    if (bad) begin
      op_o.kind = KIND_BAD;
    end else if (trunc) begin
      op_o.kind = KIND_TRUNC;
    end else if (hdr) begin
      op_o.kind = KIND_HEADER;
    end else begin
      op_o.kind = KIND_UNIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      len_q   <= '0;
      ann_q   <= '0;
      done_q  <= '0;
      widx_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      ann_q   <= ann_d;
      done_q  <= done_d;
      widx_q  <= widx_d;
    end
  end

endmodule

[src/psd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_queue
// Short register fifo of operations between the front and the back end.
// ----------------------------------------------------------------------------
module psd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  psd_pkg::psd_op_t  op_i,
  input  logic              pop_i,
  output psd_pkg::psd_op_t  head_o,
  output logic              valid_o,
  output logic              full_o
);
  import psd_pkg::*;

  psd_op_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == QCntW'(QDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ((wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + QPtrW'(1)) : wr_q;
    rd_d  = do_pop  ? ((rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + QPtrW'(1)) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[src/psd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_back
// Field buffer and record assembly into the output register.
// ----------------------------------------------------------------------------
module psd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psd_pkg::psd_op_t  head_i,
  input  logic              head_valid_i,
  output logic              pop_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output psd_pkg::psd_rec_t rec_o
);
  import psd_pkg::*;

  logic [7:0] buf_q [BufDepth];
  logic [7:0] v [BufDepth];
  logic       out_valid_q, out_valid_d;
  psd_rec_t   rec_q, rec_d;

  assign pop_o = head_valid_i && (!head_i.emit || !out_valid_q || out_ready_i);

  // current byte bypasses the buffer
  always_comb begin
    for (int i = 0; i < BufDepth; i++) begin
      v[i] = (head_i.we && (head_i.widx == BufIdxW'(i))) ? head_i.data : buf_q[i];
    end
  end

  always_comb begin
    rec_d      = '0;
    rec_d.kind = head_i.kind;
    if (head_i.kind == KIND_HEADER) begin
      rec_d.unit_count      = {v[0], v[1][7:1]};
      rec_d.prev_dir_offset = {v[2][6:0], 1'b0, v[3][7:1], v[4], v[5][7:1], v[6], v[7][7:1]};
      rec_d.next_dir_offset = {v[8][6:0], 1'b0, v[9][7:1], v[10], v[11][7:1], v[12],
                               v[13][7:1]};
    end else if (head_i.kind == KIND_UNIT) begin
      rec_d.stream_id       = v[0];
      rec_d.header_position = {v[1], v[2][7:1], v[3], v[4][7:1], v[5], v[6][7:1]};
      rec_d.ref_offset      = {v[7], v[8]};
      rec_d.pts             = {v[9][3:1], v[10], v[11][7:1], v[12], v[13][7:1]};
      rec_d.read_size       = {v[14], v[15][7:1], v[16]};
      rec_d.intra_coded     = v[17][6];
      rec_d.coding_params   = v[17][5:4];
      if (v[0] == StreamIdExt) begin
        rec_d.stream_id_ext = {v[9][6:4], v[17][3:0]};
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o && head_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.we) begin
      buf_q[head_i.widx] <= head_i.data;
    end
    if (pop_o && head_i.emit) begin
      rec_q <= rec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rec_o       = rec_q;

endmodule

[tb/psd_check_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_check_pkg
// Record tracker for the directory parser bench: follows the parse of every
// accepted byte, queues the records it should produce and checks each record
// that leaves the block against the oldest one queued.
// ----------------------------------------------------------------------------
package psd_check_pkg;

  import psd_pkg::*;

  localparam int MaxPrinted = 40;

  class record_tracker;

    psd_phase_e  phase;
    logic [16:0] pos;
    logic [15:0] pkt_len;
    logic [14:0] units_announced;
    logic [14:0] units_done;
    logic [7:0]  fbuf [BufDepth];
    psd_rec_t    records_due [$];
    int          mismatches;
    int          records_seen;

    function new();
      phase           = PH_IDLE;
      pos             = '0;
      pkt_len         = '0;
      units_announced = '0;
      units_done      = '0;
      foreach (fbuf[i]) fbuf[i] = '0;
      mismatches      = 0;
      records_seen    = 0;
    endfunction

    function int pending();
      return records_due.size();
    endfunction

    function logic [63:0] whole_at(int unsigned i, int unsigned sh);
      return 64'(fbuf[i]) << sh;
    endfunction

    // bits 7..1 of a byte, the low bit is a marker
    function logic [63:0] top7_at(int unsigned i, int unsigned sh);
      return 64'(fbuf[i][7:1]) << sh;
    endfunction

    function logic [44:0] dir_offset(int unsigned b);
      logic [63:0] w;
      w = whole_at(b, 38) | top7_at(b + 1, 30) | whole_at(b + 2, 22) |
          top7_at(b + 3, 15) | whole_at(b + 4, 7) | top7_at(b + 5, 0);
      return w[44:0];
    endfunction

    // advance the parse by one accepted byte, queue the record it completes
    function void take_byte(logic [7:0] d, logic is_first, logic is_last);
      psd_rec_t    rec;
      int unsigned p;
      int unsigned idx;
      int unsigned end_pos;
      logic [63:0] w;
      logic [7:0]  want;
      logic [14:0] limit;
      bit          at_end;
      if (is_first) begin
        phase = PH_ACTIVE;
        pos   = '0;
      end
      if (phase == PH_IDLE) return;
      rec = '0;
      p   = pos;
      idx = 0;
      if (p <= PosStart4) begin
        want = (p == PosStart4) ? StartLast : (p == PosStart3) ? StartThird : StartZero;
        if (d != want) begin
          rec.kind = KIND_BAD;
          phase    = PH_IDLE;
          records_due.push_back(rec);
          return;
        end
      end else if (p == PosLenHi) begin
        pkt_len = {d, 8'h00};
      end else if (p == PosLenLo) begin
        pkt_len = {pkt_len[15:8], d};
        if (pkt_len < MinLen) begin
          rec.kind = KIND_BAD;
          phase    = PH_IDLE;
          records_due.push_back(rec);
          return;
        end
      end else if (p < PosUnit0) begin
        fbuf[p - PosCountHi] = d;
      end else begin
        idx       = (p - PosUnit0) % BufDepth;
        fbuf[idx] = d;
      end

      end_pos = int'(pkt_len) + int'(HdrOverhead);
      at_end  = (p >= PosLenLo) && (p + 1 >= end_pos);
      // running out of bytes beats a record completed by this byte
      if (is_last && !at_end) begin
        rec.kind = KIND_TRUNC;
        phase    = PH_IDLE;
        records_due.push_back(rec);
        return;
      end
      pos = 17'(p + 1);
      if (at_end) phase = PH_IDLE;

      if (p == PosHdrLast) begin
        units_announced     = {fbuf[0], fbuf[1][7:1]};
        units_done          = '0;
        rec.kind            = KIND_HEADER;
        rec.unit_count      = units_announced;
        rec.prev_dir_offset = dir_offset(2);
        rec.next_dir_offset = dir_offset(8);
        records_due.push_back(rec);
        return;
      end

      limit = (units_announced < MaxUnits) ? units_announced : 15'(MaxUnits);
      if (p >= PosUnit0 && idx == BufDepth - 1 && units_done < limit) begin
        units_done          = units_done + 15'd1;
        rec.kind            = KIND_UNIT;
        rec.stream_id       = fbuf[0];
        w = (64'(fbuf[1][6:0]) << 37) | top7_at(2, 30) | whole_at(3, 22) |
            top7_at(4, 15) | whole_at(5, 7) | top7_at(6, 0);
        rec.header_position = {fbuf[1][7], w[43:0]};
        rec.ref_offset      = {fbuf[7], fbuf[8]};
        w = (64'(fbuf[9][3:1]) << 30) | whole_at(10, 22) | top7_at(11, 15) |
            whole_at(12, 7) | top7_at(13, 0);
        rec.pts             = w[32:0];
        w = whole_at(14, 15) | top7_at(15, 8) | whole_at(16, 0);
        rec.read_size       = w[22:0];
        rec.intra_coded     = fbuf[17][6];
        rec.coding_params   = fbuf[17][5:4];
        if (fbuf[0] == StreamIdExt) rec.stream_id_ext = {fbuf[9][6:4], fbuf[17][3:0]};
        records_due.push_back(rec);
      end
    endfunction

    task report(string what);
      if (mismatches < MaxPrinted) $display("mismatch: %s", what);
      mismatches++;
    endtask

    task diff(string name, logic [63:0] got_v, logic [63:0] want_v);
      if (got_v !== want_v)
        report($sformatf("record %0d %s got %0h want %0h", records_seen, name, got_v, want_v));
    endtask

    task check_record(psd_rec_t got);
      psd_rec_t want;
      records_seen++;
      if (records_due.size() == 0) begin
        report($sformatf("record %0d of kind %0d with none due", records_seen, got.kind));
        return;
      end
      want = records_due.pop_front();
      diff("record_kind", 64'(got.kind), 64'(want.kind));
      diff("unit_count", 64'(got.unit_count), 64'(want.unit_count));
      diff("prev_dir_offset", 64'(got.prev_dir_offset), 64'(want.prev_dir_offset));
      diff("next_dir_offset", 64'(got.next_dir_offset), 64'(want.next_dir_offset));
      diff("stream_id", 64'(got.stream_id), 64'(want.stream_id));
      diff("header_position", 64'(got.header_position), 64'(want.header_position));
      diff("ref_offset", 64'(got.ref_offset), 64'(want.ref_offset));
      diff("pts", 64'(got.pts), 64'(want.pts));
      diff("read_size", 64'(got.read_size), 64'(want.read_size));
      diff("intra_coded", 64'(got.intra_coded), 64'(want.intra_coded));
      diff("coding_params", 64'(got.coding_params), 64'(want.coding_params));
      diff("stream_id_ext", 64'(got.stream_id_ext), 64'(want.stream_id_ext));
    endtask

  endclass

endpackage

[tb/program_stream_directory_parser_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// program_stream_directory_parser_top_tb
// Feeds directory packets byte by byte: a few hand-made error cases, then
// random packets (mostly well formed, some with broken start codes, bad
// lengths, early ends and restarts, plus one packet past the unit limit).
// Both handshakes idle at random and the output is held off for long spans.
// ----------------------------------------------------------------------------
module program_stream_directory_parser_top_tb;

  import psd_pkg::*;
  import psd_check_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 5;
  localparam int ItemTarget  = 1850;
  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 20;
  localparam int LongHold    = 400;
  localparam int FirstHoldAt = 25;
  localparam int LastHoldAt  = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        first_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  record_kind_o;
  logic [14:0] unit_count_o;
  logic [44:0] prev_dir_offset_o;
  logic [44:0] next_dir_offset_o;
  logic [7:0]  stream_id_o;
  logic [44:0] header_position_o;
  logic [15:0] ref_offset_o;
  logic [32:0] pts_o;
  logic [22:0] read_size_o;
  logic        intra_coded_o;
  logic [1:0]  coding_params_o;
  logic [6:0]  stream_id_ext_o;

  record_tracker sb = new();

  logic [7:0] pkt [$];
  int         bytes_sent;
  bit         src_calm;

  program_stream_directory_parser_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .first_byte_i      (first_byte_i),
    .last_byte_i       (last_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .record_kind_o     (record_kind_o),
    .unit_count_o      (unit_count_o),
    .prev_dir_offset_o (prev_dir_offset_o),
    .next_dir_offset_o (next_dir_offset_o),
    .stream_id_o       (stream_id_o),
    .header_position_o (header_position_o),
    .ref_offset_o      (ref_offset_o),
    .pts_o             (pts_o),
    .read_size_o       (read_size_o),
    .intra_coded_o     (intra_coded_o),
    .coding_params_o   (coding_params_o),
    .stream_id_ext_o   (stream_id_ext_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // offer one item, starting and ending at a falling edge
  task automatic send_byte(input logic [7:0] d, input logic is_first, input logic is_last);
    int gap;
    int r;
    r = $urandom_range(99);
    if (src_calm || r < 65) gap = 0;
    else if (r < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(4, 24);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= d;
    first_byte_i <= is_first;
    last_byte_i  <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_packet(input int stop_at, input bit mark_last);
    for (int i = 0; i <= stop_at; i++) begin
      send_byte(pkt[i], i == 0, mark_last && i == stop_at);
      bytes_sent++;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic build_packet(input logic [14:0] count, input int n_units, input int tail);
    int len;
    len = MinLen + BufDepth * n_units + tail;
    pkt = {StartZero, StartZero, StartThird, StartLast, 8'(len >> 8), 8'(len)};
    pkt.push_back(count[14:7]);
    pkt.push_back({count[6:0], 1'($urandom)});
    repeat (12) pkt.push_back(8'($urandom));
    for (int u = 0; u < n_units; u++) begin
      pkt.push_back(($urandom_range(9) < 3) ? StreamIdExt : 8'($urandom));
      repeat (BufDepth - 1) pkt.push_back(8'($urandom));
    end
    repeat (tail) pkt.push_back(8'($urandom));
  endtask

  always @(posedge clk_i) begin : monitor
    psd_rec_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.take_byte(data_byte_i, first_byte_i, last_byte_i);
      if (out_valid_o && out_ready_i) begin
        got.kind            = psd_kind_e'(record_kind_o);
        got.unit_count      = unit_count_o;
        got.prev_dir_offset = prev_dir_offset_o;
        got.next_dir_offset = next_dir_offset_o;
        got.stream_id       = stream_id_o;
        got.header_position = header_position_o;
        got.ref_offset      = ref_offset_o;
        got.pts             = pts_o;
        got.read_size       = read_size_o;
        got.intra_coded     = intra_coded_o;
        got.coding_params   = coding_params_o;
        got.stream_id_ext   = stream_id_ext_o;
        sb.check_record(got);
      end
    end
  end

  initial begin : sink
    int hold_left;
    int hold_at;
    int r;
    bit calm;
    out_ready_i = 1'b0;
    hold_left   = 0;
    hold_at     = FirstHoldAt;
    calm        = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(149) == 0) calm = !calm;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_at != 0 && sb.records_seen >= hold_at) begin
        // long hold-off so the queue fills and the input stalls
        hold_left   = LongHold - 1;
        hold_at     = (hold_at == FirstHoldAt) ? LastHoldAt : 0;
        out_ready_i <= 1'b0;
      end else begin
        r = $urandom_range(99);
        if (calm || r < 70) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          hold_left   = (r < 94) ? $urandom_range(0, 2) : $urandom_range(4, 30);
        end
      end
    end
  end

  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("program_stream_directory_parser_top_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int n_units;
    int tail;
    int stop_at;
    int k;
    int r;
    logic [14:0] count;
    bit mark_last;
    bit big_done;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    first_byte_i = 1'b0;
    last_byte_i  = 1'b0;
    rst_ni       = 1'b0;
    src_calm     = 1'b0;
    bytes_sent   = 0;
    big_done     = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // stray items while idle are dropped
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    // wrong first start byte, also with last set
    pkt = {8'hFF};
    send_packet(0, 1'b0);
    send_packet(0, 1'b1);
    // wrong stream code
    pkt = {StartZero, StartZero, StartThird, 8'hFE};
    send_packet(3, 1'b0);
    // length under the minimum, plain and on the last item
    pkt = {StartZero, StartZero, StartThird, StartLast, 8'h00, 8'h0D};
    send_packet(5, 1'b0);
    pkt = {StartZero, StartZero, StartThird, StartLast, 8'h00, 8'h00};
    send_packet(5, 1'b1);
    // buffer ends inside the length field
    pkt = {StartZero, StartZero, StartThird, StartLast, 8'hFF};
    send_packet(4, 1'b1);
    wait_drained();

    while (bytes_sent < ItemTarget) begin
      src_calm = ($urandom_range(3) == 0);
      if (!big_done && bytes_sent >= ItemTarget / 3) begin
        // more units than the limit, count above it too
        wait_drained();
        build_packet(15'($urandom_range(MaxUnits + 1, 32767)), MaxUnits + 2,
                     $urandom_range(0, BufDepth - 1));
        send_packet(pkt.size() - 1, 1'b1);
        big_done = 1'b1;
      end else begin
        n_units = ($urandom_range(9) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
        tail    = ($urandom_range(3) == 0) ? $urandom_range(1, BufDepth - 1) : 0;
        r = $urandom_range(99);
        if (r < 60) count = 15'(n_units);
        else if (r < 80) count = 15'($urandom_range(0, n_units + 2));
        else if (r < 90) count = '0;
        else count = 15'($urandom);
        build_packet(count, n_units, tail);

        r = $urandom_range(99);
        if (r < 8) begin
          k      = $urandom_range(0, 3);
          pkt[k] = pkt[k] ^ 8'($urandom_range(1, 255));
        end else if (r < 14) begin
          pkt[PosLenHi] = 8'h00;
          pkt[PosLenLo] = 8'($urandom_range(0, MinLen - 1));
        end else if (r < 19) begin
          pkt[PosLenHi] = 8'($urandom_range(1, 255));
        end

        r = $urandom_range(99);
        if (r < 70) begin
          stop_at   = pkt.size() - 1;
          mark_last = 1'($urandom);
        end else if (r < 88) begin
          // early end, often right on a byte that would complete a record
          if ($urandom_range(1) == 1) stop_at = PosHdrLast + BufDepth * $urandom_range(0, n_units);
          else stop_at = $urandom_range(0, pkt.size() - 2);
          if (stop_at > pkt.size() - 2) stop_at = pkt.size() - 2;
          mark_last = 1'b1;
        end else begin
          // abandoned, the next packet restarts the parse
          stop_at   = $urandom_range(0, pkt.size() - 1);
          mark_last = 1'b0;
        end
        send_packet(stop_at, mark_last);

        if ($urandom_range(6) == 0)
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));
        if ($urandom_range(24) == 0) wait_drained();
      end
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("program_stream_directory_parser_top_tb: done, clean");
    end else begin
      $display("program_stream_directory_parser_top_tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
src/psd_pkg.sv
src/psd_front.sv
src/psd_queue.sv
src/psd_back.sv
src/program_stream_directory_parser_top.sv
tb/psd_check_pkg.sv
tb/program_stream_directory_parser_top_tb.sv
